>>> rtl/core/ffas_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the first-fit aligned suballocator.
// No dependencies.
package ffas_pkg;

   localparam int POOLS_DEF            = 16;
   localparam int ENTRIES_PER_POOL_DEF = 64;
   localparam int OBJECTS_PER_KIND_DEF = 1024;
   localparam logic [29:0] MIN_POOL_RESET = 30'(1024 * 1024 * 32);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_FIND  = 2'd2,
      MODE_NONE  = 2'd3
   } ffas_mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_UNBOUND = 2'd2
   } ffas_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_POOL  = 2'd0,
      REG_MIX_TILE  = 2'd1
   } ffas_reg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        object_kind;
      logic [9:0]  object_index;
      logic [15:0] thread_id;
      logic [4:0]  memory_type;
      logic [1:0]  tiling;
      logic        dedicated;
      logic [29:0] alloc_size;
      logic [4:0]  align_log2;
   } ffas_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  pool_number;
      logic [29:0] region_offset;
      logic [29:0] region_length;
      logic        first_access;
      logic        pool_created;
   } ffas_rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } ffas_csr_type;

   typedef struct packed {
      logic [29:0] start;
      logic [29:0] length;
   } ffas_entry_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_OBJ_RD, ST_OBJ_CHK, ST_REL_RD, ST_REL_CHK,
      ST_SHL_RD, ST_SHL_WR, ST_UNBIND, ST_SRCH_INIT, ST_SEARCH, ST_FRONT_CHK,
      ST_PL_ALIGN, ST_PL_CHK, ST_INS_RD, ST_INS_WR, ST_INS_PUT, ST_NEW_POOL,
      ST_BIND, ST_RESULT
   } ffas_state_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_CLR, OP_TAKE, OP_OBJ_RD, OP_SEEN_WR, OP_REL_INIT, OP_ENT_RD,
      OP_INC_I, OP_REL_HIT, OP_ENT_RD_NEXT, OP_SHL_WR, OP_DEC_COUNT, OP_UNBIND,
      OP_SRCH_INIT, OP_INC_P, OP_FIT_FRONT, OP_PL_START, OP_PL_ALIGN, OP_FIT_HOLE,
      OP_PL_NEXT, OP_ENT_RD_PREV, OP_INS_WR, OP_INS_PUT, OP_CREATE, OP_BIND,
      OP_PUSH
   } ffas_op_type;

   typedef enum logic [2:0] {
      RES_KEEP, RES_ZERO, RES_UNBOUND, RES_NOSPACE, RES_FREE, RES_FIND,
      RES_ALLOC, RES_CREATE
   } ffas_res_type;

   typedef struct packed {
      ffas_op_type  op;
      ffas_res_type res;
   } ffas_cmd_type;

   typedef struct packed {
      logic          req_valid;
      ffas_mode_type mode;
      logic          idx_bad;
      logic          bound;
      logic          size_zero;
      logic          ded;
      logic          clr_last;
      logic          rel_end;
      logic          ent_match;
      logic          shl_end;
      logic          pool_end;
      logic          pool_ok;
      logic          pool_empty;
      logic          front_fit;
      logic          hole_fit;
      logic          at_tail;
      logic          ins_done;
      logic          pools_full;
      logic          rsp_free;
   } ffas_stat_type;

endpackage

>>> rtl/core/ffas_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on ffas_pkg.
interface ffas_req_if;
   logic                  valid;
   logic                  ready;
   ffas_pkg::ffas_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ffas_rsp_if;
   logic                  valid;
   logic                  ready;
   ffas_pkg::ffas_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ffas_csr_if;
   logic                  valid;
   logic                  ready;
   ffas_pkg::ffas_csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/ffas_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the suballocator: walks objects, pools and entries by command.
// Depends on ffas_pkg.
module ffas_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ffas_pkg::ffas_stat_type stat,
   output ffas_pkg::ffas_cmd_type  cmd
);

   ffas_pkg::ffas_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffas_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffas_pkg::ST_CLEAR:     if (stat.clr_last) state_in = ffas_pkg::ST_IDLE;
         ffas_pkg::ST_IDLE:      if (stat.req_valid) state_in = ffas_pkg::ST_DECODE;
         ffas_pkg::ST_DECODE: begin
            if (stat.mode == ffas_pkg::MODE_NONE || stat.idx_bad)
               state_in = ffas_pkg::ST_RESULT;
            else
               state_in = ffas_pkg::ST_OBJ_RD;
         end
         ffas_pkg::ST_OBJ_RD:    state_in = ffas_pkg::ST_OBJ_CHK;
         ffas_pkg::ST_OBJ_CHK: begin
            priority if (stat.mode == ffas_pkg::MODE_ALLOC) begin
               if (stat.size_zero)  state_in = ffas_pkg::ST_RESULT;
               else if (stat.bound) state_in = ffas_pkg::ST_REL_RD;
               else                 state_in = ffas_pkg::ST_SRCH_INIT;
            end else if (stat.mode == ffas_pkg::MODE_FREE && stat.bound) begin
               state_in = ffas_pkg::ST_REL_RD;
            end else begin
               state_in = ffas_pkg::ST_RESULT;
            end
         end
         ffas_pkg::ST_REL_RD:
            state_in = stat.rel_end ? ffas_pkg::ST_UNBIND : ffas_pkg::ST_REL_CHK;
         ffas_pkg::ST_REL_CHK:
            state_in = stat.ent_match ? ffas_pkg::ST_SHL_RD : ffas_pkg::ST_REL_RD;
         ffas_pkg::ST_SHL_RD:
            state_in = stat.shl_end ? ffas_pkg::ST_UNBIND : ffas_pkg::ST_SHL_WR;
         ffas_pkg::ST_SHL_WR:    state_in = ffas_pkg::ST_SHL_RD;
         ffas_pkg::ST_UNBIND:
            state_in = (stat.mode == ffas_pkg::MODE_FREE) ? ffas_pkg::ST_RESULT
                                                          : ffas_pkg::ST_SRCH_INIT;
         ffas_pkg::ST_SRCH_INIT:
            state_in = stat.ded ? ffas_pkg::ST_NEW_POOL : ffas_pkg::ST_SEARCH;
         ffas_pkg::ST_SEARCH: begin
            priority if (stat.pool_end) state_in = ffas_pkg::ST_NEW_POOL;
            else if (!stat.pool_ok)     state_in = ffas_pkg::ST_SEARCH;
            else if (stat.pool_empty)   state_in = ffas_pkg::ST_INS_RD;
            else                        state_in = ffas_pkg::ST_FRONT_CHK;
         end
         ffas_pkg::ST_FRONT_CHK:
            state_in = stat.front_fit ? ffas_pkg::ST_INS_RD : ffas_pkg::ST_PL_ALIGN;
         ffas_pkg::ST_PL_ALIGN:  state_in = ffas_pkg::ST_PL_CHK;
         ffas_pkg::ST_PL_CHK: begin
            priority if (stat.hole_fit) state_in = ffas_pkg::ST_INS_RD;
            else if (stat.at_tail)      state_in = ffas_pkg::ST_SEARCH;
            else                        state_in = ffas_pkg::ST_PL_ALIGN;
         end
         ffas_pkg::ST_INS_RD:
            state_in = stat.ins_done ? ffas_pkg::ST_INS_PUT : ffas_pkg::ST_INS_WR;
         ffas_pkg::ST_INS_WR:    state_in = ffas_pkg::ST_INS_RD;
         ffas_pkg::ST_INS_PUT:   state_in = ffas_pkg::ST_BIND;
         ffas_pkg::ST_NEW_POOL:
            state_in = stat.pools_full ? ffas_pkg::ST_RESULT : ffas_pkg::ST_BIND;
         ffas_pkg::ST_BIND:      state_in = ffas_pkg::ST_RESULT;
         ffas_pkg::ST_RESULT:    if (stat.rsp_free) state_in = ffas_pkg::ST_IDLE;
         default:                state_in = ffas_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op  = ffas_pkg::OP_NOP;
      cmd.res = ffas_pkg::RES_KEEP;
      unique case (state_ff)
         ffas_pkg::ST_CLEAR:  cmd.op = ffas_pkg::OP_CLR;
         ffas_pkg::ST_IDLE:   cmd.op = ffas_pkg::OP_TAKE;
         ffas_pkg::ST_DECODE: begin
            if (stat.mode == ffas_pkg::MODE_NONE) cmd.res = ffas_pkg::RES_ZERO;
            else if (stat.idx_bad)                cmd.res = ffas_pkg::RES_UNBOUND;
         end
         ffas_pkg::ST_OBJ_RD: cmd.op = ffas_pkg::OP_OBJ_RD;
         ffas_pkg::ST_OBJ_CHK: begin
            priority if (stat.mode == ffas_pkg::MODE_ALLOC) begin
               if (stat.size_zero)  cmd.res = ffas_pkg::RES_NOSPACE;
               else if (stat.bound) cmd.op  = ffas_pkg::OP_REL_INIT;
            end else if (!stat.bound) begin
               cmd.res = ffas_pkg::RES_UNBOUND;
            end else if (stat.mode == ffas_pkg::MODE_FREE) begin
               cmd.op  = ffas_pkg::OP_REL_INIT;
               cmd.res = ffas_pkg::RES_FREE;
            end else begin
               cmd.op  = ffas_pkg::OP_SEEN_WR;
               cmd.res = ffas_pkg::RES_FIND;
            end
         end
         ffas_pkg::ST_REL_RD:  if (!stat.rel_end) cmd.op = ffas_pkg::OP_ENT_RD;
         ffas_pkg::ST_REL_CHK:
            cmd.op = stat.ent_match ? ffas_pkg::OP_REL_HIT : ffas_pkg::OP_INC_I;
         ffas_pkg::ST_SHL_RD:
            cmd.op = stat.shl_end ? ffas_pkg::OP_DEC_COUNT : ffas_pkg::OP_ENT_RD_NEXT;
         ffas_pkg::ST_SHL_WR:    cmd.op = ffas_pkg::OP_SHL_WR;
         ffas_pkg::ST_UNBIND:    cmd.op = ffas_pkg::OP_UNBIND;
         ffas_pkg::ST_SRCH_INIT: cmd.op = ffas_pkg::OP_SRCH_INIT;
         ffas_pkg::ST_SEARCH: begin
            priority if (stat.pool_end) cmd.op = ffas_pkg::OP_NOP;
            else if (!stat.pool_ok)     cmd.op = ffas_pkg::OP_INC_P;
            else if (stat.pool_empty)   cmd.op = ffas_pkg::OP_FIT_FRONT;
            else                        cmd.op = ffas_pkg::OP_ENT_RD;
         end
         ffas_pkg::ST_FRONT_CHK:
            cmd.op = stat.front_fit ? ffas_pkg::OP_FIT_FRONT : ffas_pkg::OP_PL_START;
         ffas_pkg::ST_PL_ALIGN:  cmd.op = ffas_pkg::OP_PL_ALIGN;
         ffas_pkg::ST_PL_CHK: begin
            priority if (stat.hole_fit) cmd.op = ffas_pkg::OP_FIT_HOLE;
            else if (stat.at_tail)      cmd.op = ffas_pkg::OP_INC_P;
            else                        cmd.op = ffas_pkg::OP_PL_NEXT;
         end
         ffas_pkg::ST_INS_RD:  if (!stat.ins_done) cmd.op = ffas_pkg::OP_ENT_RD_PREV;
         ffas_pkg::ST_INS_WR:  cmd.op = ffas_pkg::OP_INS_WR;
         ffas_pkg::ST_INS_PUT: begin
            cmd.op  = ffas_pkg::OP_INS_PUT;
            cmd.res = ffas_pkg::RES_ALLOC;
         end
         ffas_pkg::ST_NEW_POOL: begin
            if (stat.pools_full) begin
               cmd.res = ffas_pkg::RES_NOSPACE;
            end else begin
               cmd.op  = ffas_pkg::OP_CREATE;
               cmd.res = ffas_pkg::RES_CREATE;
            end
         end
         ffas_pkg::ST_BIND:    cmd.op = ffas_pkg::OP_BIND;
         ffas_pkg::ST_RESULT:  if (stat.rsp_free) cmd.op = ffas_pkg::OP_PUSH;
         default:              cmd.op = ffas_pkg::OP_NOP;
      endcase
   end

endmodule

>>> rtl/core/ffas_dpath.sv
`timescale 1ns / 1ps
// Datapath: pool records, entry and object memories, counters, result register.
// Depends on ffas_pkg and ffas_if.
module ffas_dpath #(
   parameter int POOLS            = ffas_pkg::POOLS_DEF,
   parameter int ENTRIES_PER_POOL = ffas_pkg::ENTRIES_PER_POOL_DEF,
   parameter int OBJECTS_PER_KIND = ffas_pkg::OBJECTS_PER_KIND_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ffas_req_if.sink               req_chan,
   ffas_rsp_if.source             rsp_chan,
   ffas_csr_if.sink               csr_chan,
   input  ffas_pkg::ffas_cmd_type cmd,
   output ffas_pkg::ffas_stat_type stat
);

   localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
   localparam int PCW   = $clog2(POOLS + 1);
   localparam int CW    = $clog2(ENTRIES_PER_POOL + 1);
   localparam int EDEP  = POOLS * ENTRIES_PER_POOL;
   localparam int EAW   = $clog2(EDEP);
   localparam int ODEP  = 2 * OBJECTS_PER_KIND;
   localparam int OAW   = $clog2(ODEP);

   typedef struct packed {
      logic          bound;
      logic [PW-1:0] pool;
      logic [29:0]   start;
      logic [29:0]   length;
      logic          seen;
   } obj_type;

   ffas_pkg::ffas_req_type  req_ff;
   ffas_pkg::ffas_rsp_type  res_ff, res_in, rsp_data_ff;
   logic                    rsp_valid_ff;
   logic [29:0]             min_pool_ff;
   logic                    mix_tile_ff;

   logic [15:0]   pool_owner [POOLS];
   logic [4:0]    pool_mtype [POOLS];
   logic [1:0]    pool_tile  [POOLS];
   logic [29:0]   pool_free  [POOLS];
   logic [29:0]   pool_total [POOLS];
   logic [CW-1:0] pool_count_ent_ff [POOLS];
   logic [PCW-1:0] pool_count_ff;

   ffas_pkg::ffas_entry_type ent_mem [EDEP];
   ffas_pkg::ffas_entry_type ent_rd_ff, ent_wr_data;
   obj_type                  obj_mem [ODEP];
   obj_type                  obj_rd_ff, obj_wr_data;

   logic [PCW-1:0] p_ff;
   logic [CW-1:0]  i_ff, pos_ff;
   logic [32:0]    end_ff, a_ff, align_mask, a_in;
   logic [29:0]    off_ff;
   logic [OAW-1:0] clr_ff;

   logic [PW-1:0]  pi;
   logic [PW-1:0]  pnew;
   logic [CW-1:0]  cnt;
   logic [OAW-1:0] obj_addr;
   logic [EAW-1:0] ent_rd_addr, ent_wr_addr;
   logic           ent_rd_en, ent_wr_en, obj_wr_en;
   logic [OAW-1:0] obj_wr_addr;
   logic [29:0]    limit;
   logic [29:0]    new_total;
   logic [32:0]    ent_end;

   assign pi   = p_ff[PW-1:0];
   assign pnew = pool_count_ff[PW-1:0];
   assign cnt  = pool_count_ent_ff[pi];
   assign obj_addr = OAW'(32'(req_ff.object_kind) * OBJECTS_PER_KIND
                          + 32'(req_ff.object_index));
   assign ent_end  = 33'(ent_rd_ff.start) + 33'(ent_rd_ff.length);
   assign align_mask = ~((33'd1 << req_ff.align_log2) - 33'd1);
   assign a_in  = (end_ff + ~align_mask) & align_mask;
   assign limit = (i_ff < cnt) ? ent_rd_ff.start : pool_total[pi];
   assign new_total = (req_ff.dedicated || min_pool_ff < req_ff.alloc_size)
                      ? req_ff.alloc_size : min_pool_ff;

   // handshakes
   assign req_chan.ready = (cmd.op == ffas_pkg::OP_TAKE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // status to controller
   always_comb begin
      stat.req_valid  = req_chan.valid;
      stat.mode       = ffas_pkg::ffas_mode_type'(req_ff.mode);
      stat.idx_bad    = 32'(req_ff.object_index) >= OBJECTS_PER_KIND;
      stat.bound      = obj_rd_ff.bound;
      stat.size_zero  = (req_ff.alloc_size == 30'd0);
      stat.ded        = req_ff.dedicated;
      stat.clr_last   = (clr_ff == OAW'(ODEP - 1));
      stat.rel_end    = (i_ff == cnt);
      stat.ent_match  = (ent_rd_ff.start == obj_rd_ff.start);
      stat.shl_end    = (32'(i_ff) + 1 >= 32'(cnt));
      stat.pool_end   = (p_ff >= pool_count_ff);
      stat.pool_ok    = (pool_owner[pi] == req_ff.thread_id)
                        && (pool_mtype[pi] == req_ff.memory_type)
                        && (pool_tile[pi] == req_ff.tiling || mix_tile_ff)
                        && (pool_free[pi] >= req_ff.alloc_size)
                        && (32'(cnt) < ENTRIES_PER_POOL);
      stat.pool_empty = (cnt == '0);
      stat.front_fit  = (ent_rd_ff.start >= req_ff.alloc_size);
      stat.hole_fit   = (34'(a_ff) + 34'(req_ff.alloc_size) <= 34'(limit));
      stat.at_tail    = (i_ff == cnt);
      stat.ins_done   = (i_ff == pos_ff);
      stat.pools_full = (32'(pool_count_ff) >= POOLS);
      stat.rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   end

   // memory port selection
   always_comb begin
      ent_rd_en   = 1'b0;
      ent_rd_addr = EAW'(32'(pi) * ENTRIES_PER_POOL + 32'(i_ff));
      ent_wr_en   = 1'b0;
      ent_wr_addr = EAW'(32'(pi) * ENTRIES_PER_POOL + 32'(i_ff));
      ent_wr_data = ent_rd_ff;
      obj_wr_en   = 1'b0;
      obj_wr_addr = obj_addr;
      obj_wr_data = obj_rd_ff;
      unique case (cmd.op)
         ffas_pkg::OP_ENT_RD, ffas_pkg::OP_PL_ALIGN: ent_rd_en = 1'b1;
         ffas_pkg::OP_ENT_RD_NEXT: begin
            ent_rd_en   = 1'b1;
            ent_rd_addr = EAW'(32'(pi) * ENTRIES_PER_POOL + 32'(i_ff) + 1);
         end
         ffas_pkg::OP_ENT_RD_PREV: begin
            ent_rd_en   = 1'b1;
            ent_rd_addr = EAW'(32'(pi) * ENTRIES_PER_POOL + 32'(i_ff) - 1);
         end
         ffas_pkg::OP_SHL_WR, ffas_pkg::OP_INS_WR: ent_wr_en = 1'b1;
         ffas_pkg::OP_INS_PUT: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = EAW'(32'(pi) * ENTRIES_PER_POOL + 32'(pos_ff));
            ent_wr_data = '{start: off_ff, length: req_ff.alloc_size};
         end
         ffas_pkg::OP_CREATE: begin
            ent_wr_en   = 1'b1;
            ent_wr_addr = EAW'(32'(pnew) * ENTRIES_PER_POOL);
            ent_wr_data = '{start: 30'd0, length: req_ff.alloc_size};
         end
         ffas_pkg::OP_CLR: begin
            obj_wr_en   = 1'b1;
            obj_wr_addr = clr_ff;
            obj_wr_data = '0;
         end
         ffas_pkg::OP_SEEN_WR: begin
            obj_wr_en        = 1'b1;
            obj_wr_data.seen = 1'b1;
         end
         ffas_pkg::OP_UNBIND: begin
            obj_wr_en         = 1'b1;
            obj_wr_data.bound = 1'b0;
         end
         ffas_pkg::OP_BIND: begin
            obj_wr_en   = 1'b1;
            obj_wr_data = '{bound: 1'b1, pool: pi, start: off_ff,
                            length: req_ff.alloc_size, seen: 1'b0};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ent_wr_en) ent_mem[ent_wr_addr] <= ent_wr_data;
      if (ent_rd_en) ent_rd_ff <= ent_mem[ent_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (obj_wr_en) obj_mem[obj_wr_addr] <= obj_wr_data;
      if (cmd.op == ffas_pkg::OP_OBJ_RD) obj_rd_ff <= obj_mem[obj_addr];
   end

   // pool records
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ffas_pkg::OP_REL_HIT: pool_free[pi] <= pool_free[pi] + ent_rd_ff.length;
         ffas_pkg::OP_INS_PUT: pool_free[pi] <= pool_free[pi] - req_ff.alloc_size;
         ffas_pkg::OP_CREATE: begin
            pool_owner[pnew] <= req_ff.thread_id;
            pool_mtype[pnew] <= req_ff.memory_type;
            pool_tile[pnew]  <= req_ff.tiling;
            pool_total[pnew] <= new_total;
            pool_free[pnew]  <= new_total - req_ff.alloc_size;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_count_ff <= '0;
         for (int k = 0; k < POOLS; k++) pool_count_ent_ff[k] <= '0;
      end else begin
         unique case (cmd.op)
            ffas_pkg::OP_DEC_COUNT: pool_count_ent_ff[pi] <= cnt - 1'b1;
            ffas_pkg::OP_INS_PUT:   pool_count_ent_ff[pi] <= cnt + 1'b1;
            ffas_pkg::OP_CREATE: begin
               pool_count_ent_ff[pnew] <= CW'(1);
               pool_count_ff           <= pool_count_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // walk counters
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ffas_pkg::OP_REL_INIT: begin
            p_ff <= PCW'(obj_rd_ff.pool);
            i_ff <= '0;
         end
         ffas_pkg::OP_INC_I, ffas_pkg::OP_SHL_WR: i_ff <= i_ff + 1'b1;
         ffas_pkg::OP_SRCH_INIT: begin
            p_ff <= '0;
            i_ff <= '0;
         end
         ffas_pkg::OP_INC_P: begin
            p_ff <= p_ff + 1'b1;
            i_ff <= '0;
         end
         ffas_pkg::OP_FIT_FRONT: begin
            off_ff <= '0;
            pos_ff <= '0;
            i_ff   <= cnt;
         end
         ffas_pkg::OP_PL_START: begin
            end_ff <= ent_end;
            i_ff   <= CW'(1);
         end
         ffas_pkg::OP_PL_ALIGN: a_ff <= a_in;
         ffas_pkg::OP_FIT_HOLE: begin
            off_ff <= a_ff[29:0];
            pos_ff <= i_ff;
            i_ff   <= cnt;
         end
         ffas_pkg::OP_PL_NEXT: begin
            end_ff <= ent_end;
            i_ff   <= i_ff + 1'b1;
         end
         ffas_pkg::OP_INS_WR: i_ff <= i_ff - 1'b1;
         ffas_pkg::OP_CREATE: begin
            p_ff   <= pool_count_ff;
            off_ff <= '0;
         end
         default: ;
      endcase
      if (cmd.op == ffas_pkg::OP_TAKE && req_chan.valid) req_ff <= req_chan.payload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.op == ffas_pkg::OP_CLR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pool_ff <= ffas_pkg::MIN_POOL_RESET;
         mix_tile_ff <= 1'b1;
      end else if (csr_chan.valid) begin
         if (csr_chan.payload.index == ffas_pkg::REG_MIN_POOL)
            min_pool_ff <= csr_chan.payload.data[29:0];
         else if (csr_chan.payload.index == ffas_pkg::REG_MIX_TILE)
            mix_tile_ff <= csr_chan.payload.data[0];
      end
   end

   // result staging
   always_comb begin
      res_in = res_ff;
      unique case (cmd.res)
         ffas_pkg::RES_KEEP:    res_in = res_ff;
         ffas_pkg::RES_ZERO:    res_in = '0;
         ffas_pkg::RES_UNBOUND: begin
            res_in        = '0;
            res_in.status = ffas_pkg::STAT_UNBOUND;
         end
         ffas_pkg::RES_NOSPACE: begin
            res_in        = '0;
            res_in.status = ffas_pkg::STAT_NOSPACE;
         end
         ffas_pkg::RES_FREE, ffas_pkg::RES_FIND: begin
            res_in = '{status: ffas_pkg::STAT_OK, pool_number: 4'(obj_rd_ff.pool),
                       region_offset: obj_rd_ff.start, region_length: obj_rd_ff.length,
                       first_access: (cmd.res == ffas_pkg::RES_FIND) && !obj_rd_ff.seen,
                       pool_created: 1'b0};
         end
         ffas_pkg::RES_ALLOC: begin
            res_in = '{status: ffas_pkg::STAT_OK, pool_number: 4'(pi),
                       region_offset: off_ff, region_length: req_ff.alloc_size,
                       first_access: 1'b1, pool_created: 1'b0};
         end
         ffas_pkg::RES_CREATE: begin
            res_in = '{status: ffas_pkg::STAT_OK, pool_number: 4'(pnew),
                       region_offset: 30'd0, region_length: req_ff.alloc_size,
                       first_access: 1'b1, pool_created: 1'b1};
         end
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (cmd.op == ffas_pkg::OP_PUSH) rsp_data_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == ffas_pkg::OP_PUSH) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

>>> rtl/core/first_fit_aligned_suballocator_unit.sv
`timescale 1ns / 1ps
// Top level of the first-fit aligned suballocator: sequencer plus datapath.
// Depends on ffas_pkg, ffas_if, ffas_ctrl and ffas_dpath.
//
//   channel   dir  transfer on        payload
//   req_chan  in   valid & ready      mode, object, thread, type, size, align
//   rsp_chan  out  valid & ready      status, pool, offset, length, flags
//   csr_chan  in   valid & ready      register index, write data
//
// Mode three, a find, an unbound free or find and a zero-size allocate go straight
// to the result; a free walks the entries of its pool. An allocate skips pools that
// do not match, walks and tries the holes of each matching pool, moves entries on
// insert or else makes a new pool (at once when dedicated). A reallocation first
// frees the old region in its pool. A held rsp_chan stalls the result state.
// After reset a clearing pass runs over the 2*OBJECTS_PER_KIND object table entries.
// One request is in flight; the next is taken while a result waits on rsp_chan.
module first_fit_aligned_suballocator_unit #(
   parameter int POOLS            = ffas_pkg::POOLS_DEF,
   parameter int ENTRIES_PER_POOL = ffas_pkg::ENTRIES_PER_POOL_DEF,
   parameter int OBJECTS_PER_KIND = ffas_pkg::OBJECTS_PER_KIND_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ffas_req_if.sink   req_chan,
   ffas_rsp_if.source rsp_chan,
   ffas_csr_if.sink   csr_chan
);

   ffas_pkg::ffas_cmd_type  cmd;
   ffas_pkg::ffas_stat_type stat;

   ffas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ffas_dpath #(
      .POOLS            (POOLS),
      .ENTRIES_PER_POOL (ENTRIES_PER_POOL),
      .OBJECTS_PER_KIND (OBJECTS_PER_KIND)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while another is in flight");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.status != ffas_pkg::STAT_OK) |->
      (rsp_chan.payload.region_offset == 30'd0 && rsp_chan.payload.region_length == 30'd0
       && !rsp_chan.payload.first_access && !rsp_chan.payload.pool_created))
      else $error("error result carries region data");

   a_created_at_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.pool_created) |->
      (rsp_chan.payload.region_offset == 30'd0 && rsp_chan.payload.first_access))
      else $error("new pool region not at offset zero");

endmodule

>>> tb/tb_first_fit_aligned_suballocator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of first_fit_aligned_suballocator_unit: directed and random
// allocate, free and find requests checked against an in-bench pool predictor.
// Depends on ffas_pkg, ffas_if and the RTL of the unit.
module tb_first_fit_aligned_suballocator_unit;

   localparam int NPOOL = ffas_pkg::POOLS_DEF;
   localparam int NENT  = ffas_pkg::ENTRIES_PER_POOL_DEF;
   localparam int NOBJ  = 2 * ffas_pkg::OBJECTS_PER_KIND_DEF;
   localparam logic [29:0] SIZE_MAX = 30'h3FFF_FFFF;

   logic clock;
   logic reset;

   ffas_req_if req_if ();
   ffas_rsp_if rsp_if ();
   ffas_csr_if csr_if ();

   first_fit_aligned_suballocator_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predicted allocator state
   logic [29:0] cfg_min_pool;
   logic        cfg_mix_tiling;
   int          pool_total_cnt;
   logic [15:0] pl_owner [NPOOL];
   logic [4:0]  pl_mtype [NPOOL];
   logic [1:0]  pl_tile  [NPOOL];
   logic [29:0] pl_free  [NPOOL];
   logic [29:0] pl_size  [NPOOL];
   int          pl_nent  [NPOOL];
   logic [29:0] rgn_start [NPOOL][NENT];
   logic [29:0] rgn_len   [NPOOL][NENT];
   bit          obj_bound [NOBJ];
   bit          obj_seen  [NOBJ];
   logic [3:0]  obj_pool  [NOBJ];
   logic [29:0] obj_start [NOBJ];
   logic [29:0] obj_len   [NOBJ];

   ffas_pkg::ffas_rsp_type pending_rsps[$];
   int  fail_count = 0;
   bit  idle_on    = 1'b1;
   int  rsp_hold   = 0;
   int  rsp_burst  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #500ms;
      $display("first_fit_aligned_suballocator_unit test failed");
      $finish;
   end

   function automatic ffas_pkg::ffas_rsp_type make_rsp(ffas_pkg::ffas_status_type st,
                                                       logic [3:0] p,
                                                       logic [29:0] off, logic [29:0] len,
                                                       logic first, logic created);
      ffas_pkg::ffas_rsp_type r;
      r.status        = st;
      r.pool_number   = p;
      r.region_offset = off;
      r.region_length = len;
      r.first_access  = first;
      r.pool_created  = created;
      return r;
   endfunction

   function automatic void insert_region(int p, int pos, logic [29:0] st, logic [29:0] len);
      for (int i = pl_nent[p]; i > pos; i--) begin
         rgn_start[p][i] = rgn_start[p][i-1];
         rgn_len[p][i]   = rgn_len[p][i-1];
      end
      rgn_start[p][pos] = st;
      rgn_len[p][pos]   = len;
      pl_nent[p]++;
   endfunction

   function automatic void release_object(int obj);
      int p;
      int cnt;
      p   = int'(obj_pool[obj]);
      cnt = pl_nent[p];
      for (int i = 0; i < cnt; i++) begin
         if (rgn_start[p][i] == obj_start[obj]) begin
            pl_free[p] = pl_free[p] + rgn_len[p][i];
            for (int j = i; j + 1 < cnt; j++) begin
               rgn_start[p][j] = rgn_start[p][j+1];
               rgn_len[p][j]   = rgn_len[p][j+1];
            end
            pl_nent[p] = cnt - 1;
            break;
         end
      end
      obj_bound[obj] = 1'b0;
   endfunction

   function automatic void bind_object(int obj, int p, logic [29:0] off, logic [29:0] sz);
      obj_bound[obj] = 1'b1;
      obj_pool[obj]  = 4'(p);
      obj_start[obj] = off;
      obj_len[obj]   = sz;
      obj_seen[obj]  = 1'b0;
   endfunction

   function automatic ffas_pkg::ffas_rsp_type predict_result(ffas_pkg::ffas_req_type r);
      int                     obj;
      int                     p;
      int                     cnt;
      int                     pos;
      logic [29:0]            sz;
      logic [29:0]            off;
      logic [29:0]            total;
      longint unsigned        align;
      longint unsigned        fin;
      longint unsigned        lim;
      longint unsigned        a;
      bit                     placed;
      ffas_pkg::ffas_rsp_type res;
      sz  = r.alloc_size;
      obj = int'({r.object_kind, r.object_index});
      if (r.mode == ffas_pkg::MODE_NONE) return make_rsp(ffas_pkg::STAT_OK, 0, 0, 0, 0, 0);
      if (r.mode == ffas_pkg::MODE_FREE) begin
         if (!obj_bound[obj]) return make_rsp(ffas_pkg::STAT_UNBOUND, 0, 0, 0, 0, 0);
         res = make_rsp(ffas_pkg::STAT_OK, obj_pool[obj], obj_start[obj], obj_len[obj],
                        0, 0);
         release_object(obj);
         return res;
      end
      if (r.mode == ffas_pkg::MODE_FIND) begin
         if (!obj_bound[obj]) return make_rsp(ffas_pkg::STAT_UNBOUND, 0, 0, 0, 0, 0);
         res = make_rsp(ffas_pkg::STAT_OK, obj_pool[obj], obj_start[obj], obj_len[obj],
                        !obj_seen[obj], 0);
         obj_seen[obj] = 1'b1;
         return res;
      end
      if (sz == 0) return make_rsp(ffas_pkg::STAT_NOSPACE, 0, 0, 0, 0, 0);
      if (obj_bound[obj]) release_object(obj);
      if (!r.dedicated) begin
         for (p = 0; p < pool_total_cnt; p++) begin
            if (pl_owner[p] != r.thread_id || pl_mtype[p] != r.memory_type) continue;
            if (pl_tile[p] != r.tiling && !cfg_mix_tiling) continue;
            if (pl_free[p] < sz || pl_nent[p] >= NENT) continue;
            cnt    = pl_nent[p];
            align  = 64'd1 << r.align_log2;
            placed = 1'b0;
            off    = '0;
            pos    = 0;
            if (cnt == 0 || rgn_start[p][0] >= sz) begin
               placed = 1'b1;
            end else begin
               for (int i = 0; i < cnt && !placed; i++) begin
                  fin = 64'(rgn_start[p][i]) + 64'(rgn_len[p][i]);
                  lim = (i + 1 < cnt) ? 64'(rgn_start[p][i+1]) : 64'(pl_size[p]);
                  a   = (fin + align - 1) & ~(align - 1);
                  if (a + 64'(sz) <= lim) begin
                     off    = a[29:0];
                     pos    = i + 1;
                     placed = 1'b1;
                  end
               end
            end
            if (placed) begin
               insert_region(p, pos, off, sz);
               pl_free[p] = pl_free[p] - sz;
               bind_object(obj, p, off, sz);
               return make_rsp(ffas_pkg::STAT_OK, 4'(p), off, sz, 1, 0);
            end
         end
      end
      if (pool_total_cnt >= NPOOL) return make_rsp(ffas_pkg::STAT_NOSPACE, 0, 0, 0, 0, 0);
      total = (r.dedicated || cfg_min_pool < sz) ? sz : cfg_min_pool;
      p = pool_total_cnt++;
      pl_owner[p] = r.thread_id;
      pl_mtype[p] = r.memory_type;
      pl_tile[p]  = r.tiling;
      pl_size[p]  = total;
      pl_free[p]  = total - sz;
      pl_nent[p]  = 0;
      insert_region(p, 0, '0, sz);
      bind_object(obj, p, '0, sz);
      return make_rsp(ffas_pkg::STAT_OK, 4'(p), 0, sz, 1, 1);
   endfunction

   // result side: not-ready bursts, long holds and checking
   initial begin
      ffas_pkg::ffas_rsp_type want;
      ffas_pkg::ffas_rsp_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (pending_rsps.size() == 0) begin
               $error("result transfer with no request outstanding");
               fail_count++;
            end else begin
               want = pending_rsps.pop_front();
               if (got.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.pool_number !== want.pool_number) begin
                  $error("pool_number expected %0d got %0d", want.pool_number,
                         got.pool_number);
                  fail_count++;
               end
               if (got.region_offset !== want.region_offset) begin
                  $error("region_offset expected %0d got %0d", want.region_offset,
                         got.region_offset);
                  fail_count++;
               end
               if (got.region_length !== want.region_length) begin
                  $error("region_length expected %0d got %0d", want.region_length,
                         got.region_length);
                  fail_count++;
               end
               if (got.first_access !== want.first_access) begin
                  $error("first_access expected %0d got %0d", want.first_access,
                         got.first_access);
                  fail_count++;
               end
               if (got.pool_created !== want.pool_created) begin
                  $error("pool_created expected %0d got %0d", want.pool_created,
                         got.pool_created);
                  fail_count++;
               end
            end
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_burst > 0) begin
            rsp_burst--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_burst = $urandom_range(0, 7);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(ffas_pkg::ffas_req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      pending_rsps.insert(pending_rsps.size(), predict_result(r));
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(ffas_pkg::ffas_reg_type idx, logic [31:0] value);
      wait_drained();
      csr_if.valid         <= 1'b1;
      csr_if.payload.index <= idx;
      csr_if.payload.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == ffas_pkg::REG_MIN_POOL) cfg_min_pool = value[29:0];
      else cfg_mix_tiling = value[0];
   endtask

   function automatic ffas_pkg::ffas_req_type build_req(logic [1:0] mode, logic kind,
                                                        int idx, int tid, int mt, int til,
                                                        logic ded, logic [29:0] sz,
                                                        int alog);
      ffas_pkg::ffas_req_type r;
      r.mode         = mode;
      r.object_kind  = kind;
      r.object_index = 10'(idx);
      r.thread_id    = 16'(tid);
      r.memory_type  = 5'(mt);
      r.tiling       = 2'(til);
      r.dedicated    = ded;
      r.alloc_size   = sz;
      r.align_log2   = 5'(alog);
      return r;
   endfunction

   task automatic test_trivial_modes();
      send_request(build_req(ffas_pkg::MODE_NONE, 1, 1023, 16'hFFFF, 31, 3, 1, SIZE_MAX, 31));
      send_request(build_req(ffas_pkg::MODE_FREE, 0, 5, 0, 0, 0, 0, 10, 0));
      send_request(build_req(ffas_pkg::MODE_FIND, 1, 1023, 0, 0, 0, 0, 10, 0));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 5, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_alloc_basics();
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 0, 0, 0, 0, 0, 100, 0));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 1, 0, 0, 2, 0, 50, 8));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 2, 0, 0, 1, 0, 7, 31));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 3, 0, 0, 0, 0, 9, 29));
      send_request(build_req(ffas_pkg::MODE_FIND, 0, 1, 0, 0, 0, 0, 0, 0));
      send_request(build_req(ffas_pkg::MODE_FIND, 0, 1, 0, 0, 0, 0, 0, 0));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 1, 0, 0, 0, 0, 300, 4));
      send_request(build_req(ffas_pkg::MODE_FREE, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(build_req(ffas_pkg::MODE_FIND, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 1, 1023, 0, 0, 3, 0, 60, 12));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 1, 512, 16'hFFFF, 31, 3, 1, SIZE_MAX, 0));
      send_request(build_req(ffas_pkg::MODE_FIND, 1, 512, 0, 0, 0, 0, 0, 0));
      send_request(build_req(ffas_pkg::MODE_FREE, 1, 512, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_config_settings();
      write_csr(ffas_pkg::REG_MIX_TILE, 32'd0);
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 10, 0, 0, 1, 0, 40, 0));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 11, 0, 0, 1, 0, 40, 3));
      write_csr(ffas_pkg::REG_MIN_POOL, 32'd1);
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 12, 3, 2, 0, 0, 64, 0));
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 13, 3, 2, 0, 0, 1, 0));
      write_csr(ffas_pkg::REG_MIN_POOL, 32'(SIZE_MAX));
      write_csr(ffas_pkg::REG_MIX_TILE, 32'd1);
      send_request(build_req(ffas_pkg::MODE_ALLOC, 0, 14, 5, 9, 2, 0, 1000, 5));
   endtask

   // 65 small regions for one owner: the last one must skip the full list of the first pool
   task automatic test_entry_list_full();
      for (int i = 0; i < NENT + 1; i++)
         send_request(build_req(ffas_pkg::MODE_ALLOC, 1, 100 + i, 7, 7, 0, 0, 1, 0));
      for (int i = 0; i < NENT + 1; i += 2)
         send_request(build_req(ffas_pkg::MODE_FREE, 1, 100 + i, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_back_pressure();
      wait_drained();
      rsp_hold = 300;
      for (int i = 0; i < 12; i++)
         send_request(build_req(ffas_pkg::MODE_FIND, 1, 100 + 2 * i + 1, 0, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   function automatic ffas_pkg::ffas_req_type random_req();
      ffas_pkg::ffas_req_type r;
      int sel;
      r = '0;
      sel = $urandom_range(0, 99);
      r.mode         = (sel < 45) ? ffas_pkg::MODE_ALLOC : (sel < 70) ? ffas_pkg::MODE_FREE :
                       (sel < 95) ? ffas_pkg::MODE_FIND : ffas_pkg::MODE_NONE;
      r.object_kind  = 1'($urandom_range(0, 1));
      r.object_index = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                    : 10'($urandom_range(0, 63));
      r.thread_id    = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 1));
      r.memory_type  = ($urandom_range(0, 49) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(0, 1));
      r.tiling       = 2'($urandom_range(0, 3));
      r.dedicated    = ($urandom_range(0, 49) == 0);
      sel = $urandom_range(0, 99);
      r.alloc_size   = (sel < 2) ? 30'd0 : (sel < 5) ? 30'($urandom_range(0, SIZE_MAX)) :
                       30'($urandom_range(1, 3000));
      sel = $urandom_range(0, 19);
      r.align_log2   = (sel == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 10));
      return r;
   endfunction

   task automatic test_random();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               write_csr(ffas_pkg::REG_MIN_POOL, 32'd65536);
            end
            1: begin
               write_csr(ffas_pkg::REG_MIX_TILE, 32'd0);
               write_csr(ffas_pkg::REG_MIN_POOL, 32'd8192);
            end
            default: begin
               write_csr(ffas_pkg::REG_MIX_TILE, 32'd1);
               write_csr(ffas_pkg::REG_MIN_POOL, 32'(ffas_pkg::MIN_POOL_RESET));
               idle_on = 1'b0;
            end
         endcase
         for (int i = 0; i < 300; i++) send_request(random_req());
      end
   endtask

   initial begin
      cfg_min_pool   = ffas_pkg::MIN_POOL_RESET;
      cfg_mix_tiling = 1'b1;
      pool_total_cnt = 0;
      for (int p = 0; p < NPOOL; p++) pl_nent[p] = 0;
      for (int o = 0; o < NOBJ; o++) obj_bound[o] = 1'b0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_trivial_modes();
      test_alloc_basics();
      test_config_settings();
      test_entry_list_full();
      test_back_pressure();
      test_random();
      wait_drained();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("first_fit_aligned_suballocator_unit test passed");
      end else begin
         $display("first_fit_aligned_suballocator_unit test failed");
      end
      $finish;
   end

endmodule
